// ----- rtl/safmv_pkg.sv -----
// Shared widths and defaults for the sort and find missing value block.
package safmv_pkg;

  localparam int unsigned SampleW       = 10;
  localparam int unsigned MissW         = 11;
  localparam int unsigned StoreDepthDef = 16;

endpackage

// ----- rtl/safmv_in_if.sv -----
// Input request channel: one sample value with its end-of-set flag.
interface safmv_in_if;

  logic                          valid;
  logic                          ready;
  logic [safmv_pkg::SampleW-1:0] sample_value;
  logic                          is_final;

  modport source (output valid, output sample_value, output is_final, input ready);
  modport sink   (input valid, input sample_value, input is_final, output ready);

endinterface

// ----- rtl/safmv_out_if.sv -----
// Output request channel: the missing value found for one closed set.
interface safmv_out_if;

  logic                        valid;
  logic                        ready;
  logic [safmv_pkg::MissW-1:0] missing_value;

  modport source (output valid, output missing_value, input ready);
  modport sink   (input valid, input missing_value, output ready);

endinterface

// ----- rtl/safmv_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module safmv_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/sort_and_find_missing_value.sv -----
// Top level: loads a set of values, exchange-sorts them in RAM and reports the first gap.
//
// The block takes one sample value per input request and stores it in a RAM of
// StoreDepth entries; values that arrive while the store is full are dropped, and the
// request flagged is_final closes the set even when its own value is dropped. The input
// is ready for each request while loading. Once the set of n values is closed, the block
// sorts the store in place by exchange sort and then walks the sorted entries in order.
// It returns the first value that is one more than an entry but is not the next entry
// (a duplicate counts as such a gap), or 0 when no gap exists or the set holds fewer
// than two values. All sorting goes through the one read port and one write port of the
// store: each pass over position i holds the running minimum in a register, streams the
// later entries through the read port at one per cycle and writes exchanged entries
// back behind it. After the scan, the result passes to the output register as soon as
// that register is free. While the block sorts and scans, the input is not ready; it
// becomes ready again as soon as the result sits in the output register, so the next
// set can load while the result waits.
module sort_and_find_missing_value #(
  parameter int unsigned StoreDepth = safmv_pkg::StoreDepthDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  safmv_in_if.sink   in_i,
  safmv_out_if.source out_o
);

  import safmv_pkg::*;

  localparam int unsigned AW = $clog2(StoreDepth);
  localparam int unsigned CW = $clog2(StoreDepth + 1);
  localparam logic [CW-1:0] DepthC = CW'(StoreDepth);

  // Sequencer states.
  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_PICK  = 3'd1;
  localparam logic [2:0] ST_CMP   = 3'd2;
  localparam logic [2:0] ST_PUT   = 3'd3;
  localparam logic [2:0] ST_SCAN0 = 3'd4;
  localparam logic [2:0] ST_SCAN  = 3'd5;
  localparam logic [2:0] ST_EMIT  = 3'd6;

  logic [2:0]         state_q, state_d;
  logic [CW-1:0]      fill_q, fill_d;
  logic [CW-1:0]      i_q, i_d;
  logic [CW-1:0]      j_q, j_d;
  logic [SampleW-1:0] a_q, a_d;
  logic [MissW-1:0]   res_q, res_d;
  logic               out_valid_q, out_valid_d;
  logic [MissW-1:0]   out_data_q, out_data_d;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [SampleW-1:0] ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [SampleW-1:0] ram_rdata;

  logic [CW-1:0]      n_new;
  logic [CW-1:0]      ip1;
  logic [CW-1:0]      jp1;
  logic [MissW-1:0]   succ;

  safmv_ram #(
    .Width (SampleW),
    .Depth (StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_i.ready          = (state_q == ST_LOAD);
  assign out_o.valid         = out_valid_q;
  assign out_o.missing_value = out_data_q;

  // Count after this request; a value offered to a full store is dropped.
  assign n_new = fill_q + CW'(fill_q < DepthC);
  assign ip1   = i_q + CW'(1);
  assign jp1   = j_q + CW'(1);
  assign succ  = {1'b0, a_q} + MissW'(1);

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    i_d         = i_q;
    j_d         = j_q;
    a_d         = a_q;
    res_d       = res_q;
    out_valid_d = out_valid_q & ~out_o.ready;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = a_q;
    ram_re      = 1'b0;
    ram_raddr   = '0;

    unique case (state_q)
      ST_LOAD: begin
        if (in_i.valid) begin
          if (fill_q < DepthC) begin
            ram_we    = 1'b1;
            ram_waddr = fill_q[AW-1:0];
            ram_wdata = in_i.sample_value;
          end
          fill_d = n_new;
          if (in_i.is_final) begin
            if (n_new < CW'(2)) begin
              // Fewer than two values leave no pair to check.
              res_d   = '0;
              state_d = ST_EMIT;
            end else begin
              i_d       = '0;
              ram_re    = 1'b1;
              ram_raddr = '0;
              state_d   = ST_PICK;
            end
          end
        end
      end

      ST_PICK: begin
        // Entry i arrives; it becomes the running minimum for this pass.
        a_d       = ram_rdata;
        j_d       = ip1;
        ram_re    = 1'b1;
        ram_raddr = ip1[AW-1:0];
        state_d   = ST_CMP;
      end

      ST_CMP: begin
        // Exchange: the larger value goes back to position j.
        if (a_q > ram_rdata) begin
          ram_we    = 1'b1;
          ram_waddr = j_q[AW-1:0];
          ram_wdata = a_q;
          a_d       = ram_rdata;
        end
        if (jp1 < fill_q) begin
          j_d       = jp1;
          ram_re    = 1'b1;
          ram_raddr = jp1[AW-1:0];
        end else begin
          state_d = ST_PUT;
        end
      end

      ST_PUT: begin
        // Position i receives the minimum of the pass.
        ram_we    = 1'b1;
        ram_waddr = i_q[AW-1:0];
        ram_wdata = a_q;
        if (ip1 < fill_q - CW'(1)) begin
          i_d       = ip1;
          ram_re    = 1'b1;
          ram_raddr = ip1[AW-1:0];
          state_d   = ST_PICK;
        end else begin
          state_d = ST_SCAN0;
        end
      end

      ST_SCAN0: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
        j_d       = '0;
        state_d   = ST_SCAN;
      end

      ST_SCAN: begin
        if ((j_q != '0) && (succ != {1'b0, ram_rdata})) begin
          res_d   = succ;
          state_d = ST_EMIT;
        end else begin
          a_d = ram_rdata;
          if (jp1 < fill_q) begin
            j_d       = jp1;
            ram_re    = 1'b1;
            ram_raddr = jp1[AW-1:0];
          end else begin
            res_d   = '0;
            state_d = ST_EMIT;
          end
        end
      end

      ST_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          fill_d      = '0;
          state_d     = ST_LOAD;
        end
      end

      default: begin
        state_d = ST_LOAD;
        fill_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q        <= i_d;
    j_q        <= j_d;
    a_q        <= a_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  // The fill count never passes the store size.
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= DepthC)
    else $error("fill count exceeds store depth");

  // The compare pass only visits entries after position i and inside the set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) |-> ((j_q > i_q) && (j_q < fill_q)))
    else $error("compare index out of range");

  // The store is never read and written at the same entry in one cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("read and write collide on one entry");

  // Handing over a result starts a fresh, empty set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_EMIT) && (!out_valid_q || out_o.ready))
      |=> ((state_q == ST_LOAD) && (fill_q == '0) && out_valid_q))
    else $error("result handover did not restart loading");

endmodule
